// ----- src/hgb_pkg.sv -----
package hgb_pkg;

   // Number of table lanes; group g lives in lane g % LANES, row g / LANES.
   localparam int LANES     = 4;
   localparam int LANE_BITS = 2;

   localparam int KEY_W      = 128;
   localparam int REQ_DATA_W = 392;
   localparam int RSP_DATA_W = 544;

   localparam logic [2:0] ST_EXISTING = 3'd0;
   localparam logic [2:0] ST_NEW      = 3'd1;
   localparam logic [2:0] ST_DROPPED  = 3'd2;
   localparam logic [2:0] ST_GROUP    = 3'd3;
   localparam logic [2:0] ST_LAST     = 3'd4;
   localparam logic [2:0] ST_NONE     = 3'd5;

   localparam logic REG_NUM_AGGS = 1'b0;
   localparam logic REG_TOP_K    = 1'b1;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   // What one lane reports about the table row it has just read.
   typedef struct packed {
      logic             hit;
      logic             elig;
      logic [31:0]      cnt;
      logic [KEY_W-1:0] key;
   } lane_res_type;

   // Probe broadcast to all lanes during a scan.
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             first;
      logic [31:0]      prev_cnt;
   } probe_type;

endpackage

// ----- src/hgb_lane.sv -----
module hgb_lane #(
   parameter int GROUP_CAPACITY = 1024,
   parameter int LANE_ID = 0,
   localparam int UW = $clog2(GROUP_CAPACITY + 1),
   localparam int BANK_DEPTH = (GROUP_CAPACITY + hgb_pkg::LANES - 1) / hgb_pkg::LANES,
   localparam int RW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [RW-1:0]            wr_row,
   input  logic [hgb_pkg::KEY_W-1:0] wr_key,
   input  logic [31:0]              wr_cnt,
   input  logic [RW-1:0]            rd_row,
   input  logic [RW-1:0]            row_q,
   input  hgb_pkg::probe_type       probe,
   input  logic [UW-1:0]            prev_idx,
   input  logic [UW-1:0]            used,
   output hgb_pkg::lane_res_type    res
);

   localparam int GXW = RW + hgb_pkg::LANE_BITS;
   localparam int XW = GXW + UW;

   logic [hgb_pkg::KEY_W-1:0] key_mem [BANK_DEPTH];
   logic [31:0]               cnt_mem [BANK_DEPTH];
   logic [hgb_pkg::KEY_W-1:0] key_q_ff;
   logic [31:0]               cnt_q_ff;
   logic [GXW-1:0]            gidx;
   logic [XW-1:0]             gidx_x;
   logic                      in_range;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_row] <= wr_key;
         cnt_mem[wr_row] <= wr_cnt;
      end
      key_q_ff <= key_mem[rd_row];
      cnt_q_ff <= cnt_mem[rd_row];
   end

   assign gidx     = {row_q, hgb_pkg::LANE_BITS'(LANE_ID)};
   assign gidx_x   = {{UW{1'b0}}, gidx};
   assign in_range = gidx_x < {{GXW{1'b0}}, used};

   always_comb begin
      res.key  = key_q_ff;
      res.cnt  = cnt_q_ff;
      res.hit  = in_range && (key_q_ff == probe.key);
      // Ranked after the previous pick: lower count, or equal count and later group.
      res.elig = in_range && (probe.first || (cnt_q_ff < probe.prev_cnt) ||
                 ((cnt_q_ff == probe.prev_cnt) && (gidx_x > {{GXW{1'b0}}, prev_idx})));
   end

endmodule

// ----- src/hgb_merge.sv -----
module hgb_merge #(
   parameter int GROUP_CAPACITY = 1024,
   localparam int UW = $clog2(GROUP_CAPACITY + 1),
   localparam int BANK_DEPTH = (GROUP_CAPACITY + hgb_pkg::LANES - 1) / hgb_pkg::LANES,
   localparam int RW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            clear,
   input  logic                            update,
   input  logic [RW-1:0]                   row_q,
   input  hgb_pkg::lane_res_type           lanes [hgb_pkg::LANES],
   output logic                            hit,
   output logic [hgb_pkg::LANE_BITS-1:0]   hit_lane,
   output logic [UW-1:0]                   best_idx,
   output logic [31:0]                     best_cnt
);

   logic                          found_ff;
   logic [UW-1:0]                 idx_ff;
   logic [31:0]                   cnt_ff;
   logic                          cand_found;
   logic [hgb_pkg::LANE_BITS-1:0] cand_lane;
   logic [31:0]                   cand_cnt;
   logic                          take;

   always_comb begin
      hit        = 1'b0;
      hit_lane   = '0;
      cand_found = 1'b0;
      cand_lane  = '0;
      cand_cnt   = '0;
      for (int l = hgb_pkg::LANES - 1; l >= 0; l--) begin
         if (lanes[l].hit) begin
            hit      = 1'b1;
            hit_lane = hgb_pkg::LANE_BITS'(l);
         end
      end
      // Lanes hold increasing group numbers, so the first of equal counts wins.
      for (int l = 0; l < hgb_pkg::LANES; l++) begin
         if (lanes[l].elig && (!cand_found || (lanes[l].cnt > cand_cnt))) begin
            cand_found = 1'b1;
            cand_lane  = hgb_pkg::LANE_BITS'(l);
            cand_cnt   = lanes[l].cnt;
         end
      end
      take = cand_found && (!found_ff || (cand_cnt > cnt_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (clear) begin
         found_ff <= 1'b0;
      end else if (update && take) begin
         found_ff <= 1'b1;
      end
      if (update && take) begin
         idx_ff <= UW'({row_q, cand_lane});
         cnt_ff <= cand_cnt;
      end
   end

   assign best_idx = idx_ff;
   assign best_cnt = cnt_ff;

endmodule

// ----- src/hash_group_by_aggregate_topk_unit.sv -----
// Row word: the key probe compares four table lanes per cycle over the rows in use, then
// one read and one write of the entry.
// Fetch word with top_k zero: one read of the entry at the cursor; on an empty table the
// reply has status ST_NONE. With top_k set: one pass over the counts per rank, up to the list position.
// One word is worked on at a time. Reset is synchronous: it empties the table, clears the
// cursor and output valid, sets num_aggs to 1 and top_k to 0; memory contents are left as they are.
module hash_group_by_aggregate_topk_unit #(
   parameter int GROUP_CAPACITY = 1024,
   parameter int MAX_AGGS = 4,
   parameter int MAX_TOP_K = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // key_a, key_b, agg_value_0..3, valid_mask, zero pad
   input  logic [hgb_pkg::REQ_DATA_W-1:0]   req_tdata,
   // opcode
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // group_key_a, group_key_b, row_count, sum_0..3, count_0..3
   output logic [hgb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic [2:0]                       rsp_tuser,
   input  logic                             csr_wr_en,
   input  logic                             csr_index,
   input  logic [4:0]                       csr_wdata
);

   localparam int UW = $clog2(GROUP_CAPACITY + 1);
   localparam int GW = (GROUP_CAPACITY > 1) ? $clog2(GROUP_CAPACITY) : 1;
   localparam int BANK_DEPTH = (GROUP_CAPACITY + hgb_pkg::LANES - 1) / hgb_pkg::LANES;
   localparam int RW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int RCW = $clog2(BANK_DEPTH + 1);
   localparam int KW = $clog2(MAX_TOP_K + 1);
   localparam int LW = (UW > KW) ? UW : KW;
   localparam int NW = $clog2(MAX_AGGS + 1);
   localparam int RKW = (MAX_TOP_K > 1) ? $clog2(MAX_TOP_K) : 1;
   localparam int LB = hgb_pkg::LANE_BITS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_UPD  = 3'd3;
   localparam logic [2:0] S_PUSH = 3'd4;

   logic [2:0]                     state_ff;
   logic                           op_ff;
   logic [hgb_pkg::KEY_W-1:0]      key_ff;
   logic [63:0]                    val_ff [4];
   logic [3:0]                     mask_ff;
   logic [UW-1:0]                  used_ff;
   logic [UW-1:0]                  cursor_ff;
   logic [2:0]                     num_aggs_ff;
   logic [4:0]                     top_k_ff;
   logic [RCW-1:0]                 addr_ff;
   logic                           vld_ff;
   logic [RW-1:0]                  rowq_ff;
   logic [UW-1:0]                  g_ff;
   logic                           new_ff;
   logic                           first_ff;
   logic [31:0]                    prev_cnt_ff;
   logic [UW-1:0]                  prev_idx_ff;
   logic [RKW-1:0]                 rank_ff;
   logic [RKW-1:0]                 target_ff;
   logic [2:0]                     status_ff;
   logic [2:0]                     res_status_ff;
   logic [hgb_pkg::RSP_DATA_W-1:0] res_data_ff;
   logic                           rsp_valid_ff;
   logic [2:0]                     rsp_status_ff;
   logic [hgb_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic [RCW-1:0]                 rows_tot;
   logic                           issuing;
   logic                           scan_end;
   logic                           restart;
   logic                           merge_clr;
   logic                           rsp_load;
   logic                           hit;
   logic [LB-1:0]                  hit_lane;
   logic [UW-1:0]                  best_idx;
   logic [31:0]                    best_cnt;
   logic [LB-1:0]                  glane;
   logic [UW-1:0]                  gshift;
   logic [RW-1:0]                  grow;
   logic [RW-1:0]                  rd_row;
   logic                           tbl_we;
   hgb_pkg::probe_type             probe;
   hgb_pkg::lane_res_type          lane_res [hgb_pkg::LANES];
   hgb_pkg::lane_res_type          sel;

   logic [KW-1:0]                  k;
   logic [LW-1:0]                  len;
   logic [UW-1:0]                  ceff;
   logic [UW-1:0]                  cnext;
   logic                           clast;
   logic [NW-1:0]                  n_aggs;

   logic [31:0]                    row_cnt_new;
   logic [63:0]                    sum_rd [4];
   logic [31:0]                    vc_rd [4];
   logic [63:0]                    new_sum [4];
   logic [31:0]                    new_vc [4];
   logic [63:0]                    out_sum [4];
   logic [31:0]                    out_vc [4];
   logic [hgb_pkg::KEY_W-1:0]      out_key;
   logic [31:0]                    out_rc;
   logic [hgb_pkg::RSP_DATA_W-1:0] packed_res;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign rows_tot  = RCW'(({1'b0, used_ff} + (UW + 1)'(hgb_pkg::LANES - 1)) >> LB);
   assign issuing   = addr_ff < rows_tot;
   assign scan_end  = !issuing && !vld_ff;
   assign restart   = (state_ff == S_SCAN) && op_ff && scan_end && (rank_ff != target_ff);
   assign merge_clr = (state_ff == S_IDLE) || restart;
   assign rsp_load  = (state_ff == S_PUSH) && (!rsp_valid_ff || rsp_tready);

   assign glane  = g_ff[LB-1:0];
   assign gshift = g_ff >> LB;
   assign grow   = gshift[RW-1:0];
   assign rd_row = (state_ff == S_SCAN) ? addr_ff[RW-1:0] : grow;
   assign tbl_we = (state_ff == S_UPD) && !op_ff;

   assign probe.key      = key_ff;
   assign probe.first    = first_ff;
   assign probe.prev_cnt = prev_cnt_ff;

   for (genvar l = 0; l < hgb_pkg::LANES; l++) begin : g_lane
      hgb_lane #(
         .GROUP_CAPACITY (GROUP_CAPACITY),
         .LANE_ID        (l)
      ) u_lane (
         .clock    (clock),
         .wr_en    (tbl_we && (glane == LB'(l))),
         .wr_row   (grow),
         .wr_key   (key_ff),
         .wr_cnt   (row_cnt_new),
         .rd_row   (rd_row),
         .row_q    (rowq_ff),
         .probe    (probe),
         .prev_idx (prev_idx_ff),
         .used     (used_ff),
         .res      (lane_res[l])
      );
   end

   hgb_merge #(
      .GROUP_CAPACITY (GROUP_CAPACITY)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .clear    (merge_clr),
      .update   ((state_ff == S_SCAN) && vld_ff),
      .row_q    (rowq_ff),
      .lanes    (lane_res),
      .hit      (hit),
      .hit_lane (hit_lane),
      .best_idx (best_idx),
      .best_cnt (best_cnt)
   );

   // Aggregate columns, one memory pair per column, addressed by group number.
   for (genvar i = 0; i < 4; i++) begin : g_col
      if (i < MAX_AGGS) begin : g_mem
         logic [63:0] sum_mem [GROUP_CAPACITY];
         logic [31:0] vc_mem [GROUP_CAPACITY];
         logic [63:0] sum_q_ff;
         logic [31:0] vc_q_ff;
         always_ff @(posedge clock) begin
            if (tbl_we) begin
               sum_mem[g_ff[GW-1:0]] <= new_sum[i];
               vc_mem[g_ff[GW-1:0]]  <= new_vc[i];
            end
            sum_q_ff <= sum_mem[g_ff[GW-1:0]];
            vc_q_ff  <= vc_mem[g_ff[GW-1:0]];
         end
         assign sum_rd[i] = sum_q_ff;
         assign vc_rd[i]  = vc_q_ff;
      end else begin : g_none
         assign sum_rd[i] = '0;
         assign vc_rd[i]  = '0;
      end
   end

   // Fetch list bookkeeping for the word at the input.
   always_comb begin
      k      = (32'(top_k_ff) > MAX_TOP_K) ? KW'(MAX_TOP_K) : KW'(top_k_ff);
      n_aggs = (32'(num_aggs_ff) > MAX_AGGS) ? NW'(MAX_AGGS) : NW'(num_aggs_ff);
      if ((k == '0) || (LW'(used_ff) < LW'(k))) begin
         len = LW'(used_ff);
      end else begin
         len = LW'(k);
      end
      ceff  = (LW'(cursor_ff) >= len) ? '0 : cursor_ff;
      clast = (LW'(ceff) + LW'(1)) >= len;
      cnext = clast ? '0 : ceff + UW'(1);
   end

   always_comb begin
      sel = lane_res[0];
      for (int l = 1; l < hgb_pkg::LANES; l++) begin
         if (glane == LB'(l)) begin
            sel = lane_res[l];
         end
      end
      // A fresh group has never been written, so its stored values count as zero.
      row_cnt_new = new_ff ? 32'd1 :
                    ((sel.cnt == hgb_pkg::COUNT_MAX) ? sel.cnt : sel.cnt + 32'd1);
      for (int i = 0; i < 4; i++) begin
         logic [63:0] sb;
         logic [31:0] cb;
         logic        act;
         sb  = new_ff ? 64'd0 : sum_rd[i];
         cb  = new_ff ? 32'd0 : vc_rd[i];
         act = !op_ff && (32'(n_aggs) > i) && mask_ff[i];
         new_sum[i] = act ? sb + val_ff[i] : sb;
         new_vc[i]  = (act && (cb != hgb_pkg::COUNT_MAX)) ? cb + 32'd1 : cb;
         out_sum[i] = op_ff ? sum_rd[i] : new_sum[i];
         out_vc[i]  = op_ff ? vc_rd[i] : new_vc[i];
      end
      out_key = op_ff ? sel.key : key_ff;
      out_rc  = op_ff ? sel.cnt : row_cnt_new;
      packed_res = {out_vc[3], out_vc[2], out_vc[1], out_vc[0],
                    out_sum[3], out_sum[2], out_sum[1], out_sum[0], out_rc, out_key};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_aggs_ff <= 3'd1;
         top_k_ff    <= 5'd0;
      end else if (csr_wr_en) begin
         case (csr_index)
            hgb_pkg::REG_NUM_AGGS: num_aggs_ff <= csr_wdata[2:0];
            hgb_pkg::REG_TOP_K:    top_k_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vld_ff       <= 1'b0;
         used_ff      <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff     <= req_tuser;
                  key_ff    <= req_tdata[127:0];
                  val_ff[0] <= req_tdata[191:128];
                  val_ff[1] <= req_tdata[255:192];
                  val_ff[2] <= req_tdata[319:256];
                  val_ff[3] <= req_tdata[383:320];
                  mask_ff   <= req_tdata[387:384];
                  addr_ff   <= '0;
                  vld_ff    <= 1'b0;
                  if (!req_tuser) begin
                     cursor_ff <= '0;
                     state_ff  <= S_SCAN;
                  end else if (used_ff == '0) begin
                     res_status_ff <= hgb_pkg::ST_NONE;
                     res_data_ff   <= '0;
                     cursor_ff     <= '0;
                     state_ff      <= S_PUSH;
                  end else begin
                     cursor_ff <= cnext;
                     status_ff <= clast ? hgb_pkg::ST_LAST : hgb_pkg::ST_GROUP;
                     new_ff    <= 1'b0;
                     if (k == '0) begin
                        g_ff     <= ceff;
                        state_ff <= S_READ;
                     end else begin
                        rank_ff   <= '0;
                        target_ff <= RKW'(ceff);
                        first_ff  <= 1'b1;
                        state_ff  <= S_SCAN;
                     end
                  end
               end
            end
            S_SCAN: begin
               // A key hit ends the probe, so nothing read after it counts.
               vld_ff  <= issuing && (op_ff || !(vld_ff && hit));
               rowq_ff <= addr_ff[RW-1:0];
               if (issuing) begin
                  addr_ff <= addr_ff + RCW'(1);
               end
               if (!op_ff) begin
                  if (vld_ff && hit) begin
                     g_ff     <= UW'({rowq_ff, hit_lane});
                     new_ff   <= 1'b0;
                     state_ff <= S_READ;
                  end else if (scan_end) begin
                     if (32'(used_ff) >= GROUP_CAPACITY) begin
                        res_status_ff <= hgb_pkg::ST_DROPPED;
                        res_data_ff   <= {{(hgb_pkg::RSP_DATA_W - hgb_pkg::KEY_W){1'b0}},
                                          key_ff};
                        state_ff      <= S_PUSH;
                     end else begin
                        g_ff     <= used_ff;
                        used_ff  <= used_ff + UW'(1);
                        new_ff   <= 1'b1;
                        state_ff <= S_READ;
                     end
                  end
               end else if (scan_end) begin
                  if (rank_ff == target_ff) begin
                     g_ff     <= best_idx;
                     state_ff <= S_READ;
                  end else begin
                     // Next rank: everything strictly behind the group just picked.
                     prev_cnt_ff <= best_cnt;
                     prev_idx_ff <= best_idx;
                     first_ff    <= 1'b0;
                     rank_ff     <= rank_ff + RKW'(1);
                     addr_ff     <= '0;
                  end
               end
            end
            S_READ: begin
               state_ff <= S_UPD;
            end
            S_UPD: begin
               res_status_ff <= op_ff ? status_ff :
                                (new_ff ? hgb_pkg::ST_NEW : hgb_pkg::ST_EXISTING);
               res_data_ff   <= packed_res;
               state_ff      <= S_PUSH;
            end
            S_PUSH: begin
               if (rsp_load) begin
                  rsp_data_ff   <= res_data_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
